// ===== sv/sorted_table_binary_search_defines.svh =====
// Assertion macros for the sorted table binary search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Clocked check, held off while reset is asserted.
`define STBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define STBS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

	localparam int STBS_DEPTH = 1024;
	localparam int DATA_W     = 32;
	localparam int POS_W      = 10;
	localparam int REQ_W      = 2;
	localparam int STAT_W     = 2;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 2'd0,
		REQ_SEARCH = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_CMP,
		S_RESP
	} state_t;

endpackage

// ===== sv/stbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/sorted_table_binary_search.sv =====
// Sorted table binary search: top level with sequencer, bounds and output register.
// Append beats (tuser 0) store tdata at the next free entry; the table is meant to be
// loaded in ascending signed order and is not checked. Search beats (tuser 1) run a
// binary search over the filled entries and return status 0 with the 0-based position
// of the first equal element met, or status 1 with position 0. Clear beats (tuser 2)
// empty the table, and code 3 does nothing; both return status 0. An append to a full
// table is dropped with status 2. Every beat in gives one beat out. One item is in work
// at a time: an append or clear goes from IDLE straight to RESP, while a search repeats
// a probe (a RAM read at the midpoint in CHECK, then a compare with the key in CMP)
// until a match or an empty interval sends it to RESP. The output register lets the
// next beat in be taken while a result waits; a second finished result holds the input
// off until the first is taken.
`include "sorted_table_binary_search_defines.svh"

module sorted_table_binary_search
	import stbs_pkg::*;
#(
	parameter int DEPTH = STBS_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [DATA_W-1:0]      s_axis_tdata,  // [31:0] value
	input  logic [REQ_W-1:0]       s_axis_tuser,  // [1:0] req_type
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [9:0] position, [15:10] zero
	output logic [STAT_W-1:0]      m_axis_tuser   // [1:0] status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     lo_q, hi_q;
	logic [DATA_W-1:0] key_q;
	logic [AW-1:0]     mid_q;
	status_t           rsl_status_q;
	logic [POS_W-1:0]  rsl_pos_q;
	logic              m_valid_q;
	status_t           m_status_q;
	logic [POS_W-1:0]  m_pos_q;

	logic              in_beat;
	logic              full;
	logic              lo_lt_hi;
	logic [CW:0]       sum_w;
	logic [AW-1:0]     mid_w;
	logic [DATA_W-1:0] rd_data;
	logic              key_eq, key_gt;
	logic              ram_we, ram_re, out_load;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign full     = (count_q == CW'(DEPTH));
	assign lo_lt_hi = (lo_q < hi_q);
	assign sum_w    = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
	assign mid_w    = AW'(sum_w >> 1);
	assign key_eq   = (rd_data == key_q);
	assign key_gt   = ($signed(key_q) > $signed(rd_data));

	stbs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(count_q)),
		.wdata(s_axis_tdata),
		.re   (ram_re),
		.raddr(mid_w),
		.rdata(rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					state_d = (s_axis_tuser == REQ_SEARCH) ? S_CHECK : S_RESP;
				end
			end
			S_CHECK: begin
				state_d = lo_lt_hi ? S_CMP : S_RESP;
			end
			S_CMP: begin
				state_d = key_eq ? S_RESP : S_CHECK;
			end
			S_RESP: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		ram_re        = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE:  s_axis_tready = 1'b1;
			S_CHECK: ram_re = lo_lt_hi;
			S_RESP:  out_load = !m_valid_q || m_axis_tready;
			default: s_axis_tready = 1'b0;
		endcase
		ram_we = in_beat && (s_axis_tuser == REQ_APPEND) && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_beat) begin
				case (s_axis_tuser)
					REQ_APPEND: begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end
					end
					REQ_SEARCH: begin
						lo_q <= '0;
						hi_q <= count_q;
					end
					REQ_CLEAR: count_q <= '0;
					default:   count_q <= count_q;
				endcase
			end
			if (state_q == S_CMP && !key_eq) begin
				if (key_gt) begin
					lo_q <= CW'(mid_q) + CW'(1);
				end else begin
					hi_q <= CW'(mid_q);
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			key_q     <= s_axis_tdata;
			rsl_pos_q <= '0;
			case (s_axis_tuser)
				REQ_APPEND: rsl_status_q <= full ? STAT_FULL : STAT_OK;
				REQ_SEARCH: rsl_status_q <= STAT_NOT_FOUND;
				default:    rsl_status_q <= STAT_OK;
			endcase
		end
		if (state_q == S_CHECK) begin
			mid_q <= mid_w;
		end
		if (state_q == S_CMP && key_eq) begin
			rsl_status_q <= STAT_OK;
			rsl_pos_q    <= POS_W'(mid_q);
		end
		if (out_load) begin
			m_status_q <= rsl_status_q;
			m_pos_q    <= rsl_pos_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(m_pos_q);
	assign m_axis_tuser  = m_status_q;

	`STBS_ASSERT(a_count_bounded, count_q <= CW'(DEPTH), "element count above depth")
	`STBS_ASSERT(a_cmp_nonempty, state_q == S_CMP |-> lo_q < hi_q, "probe on empty interval")
	`STBS_ASSERT(a_hi_in_table, state_q == S_CHECK |-> hi_q <= count_q,
		"search bound beyond filled entries")
	`STBS_ASSERT(a_search_starts, in_beat && s_axis_tuser == REQ_SEARCH |=> state_q == S_CHECK,
		"search beat did not start probing")
	`STBS_ASSERT(a_pos_zero, m_valid_q && m_status_q != STAT_OK |-> m_pos_q == '0,
		"nonzero position on failed request")

endmodule

// ===== tb/tb_sorted_table_binary_search.sv =====
// Self-checking testbench for the sorted table binary search block.
module tb_sorted_table_binary_search;
	import stbs_pkg::*;

	localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BEATS = 1750;

	typedef struct packed {
		status_t           st;
		logic [POS_W-1:0]  pos;
	} result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [DATA_W-1:0]      s_axis_tdata = '0;   // [31:0] value
	logic [REQ_W-1:0]       s_axis_tuser = '0;   // [1:0] req_type
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [9:0] position, [15:10] zero
	logic [STAT_W-1:0]      m_axis_tuser;        // [1:0] status

	sorted_table_binary_search dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// shadow copy of the table
	logic signed [DATA_W-1:0] table_mem [STBS_DEPTH];
	int                       table_fill = 0;
	result_t                  awaited_results [$];

	int  errors = 0;
	int  beats_in = 0;
	int  appends_ok = 0;
	int  appends_dropped = 0;
	int  search_hits = 0;
	int  search_misses = 0;
	int  clears_nops = 0;
	int  tx_calm = 0;
	bit  tx_burst = 1'b0;
	bit  stall_req = 1'b0;
	int  rx_left = 0;
	bit  rx_level = 1'b0;

	function automatic result_t table_step(input logic [REQ_W-1:0] req,
			input logic signed [DATA_W-1:0] val);
		result_t res;
		int lo, hi, mid;
		res.st = STAT_OK;
		res.pos = '0;
		case (req)
			REQ_APPEND: begin
				if (table_fill >= STBS_DEPTH) begin
					res.st = STAT_FULL;
				end else begin
					table_mem[table_fill] = val;
					table_fill++;
				end
			end
			REQ_SEARCH: begin
				lo = 0;
				hi = table_fill;
				res.st = STAT_NOT_FOUND;
				while (lo < hi) begin
					mid = (lo + hi - 1) >> 1;
					if (table_mem[mid] == val) begin
						res.st = STAT_OK;
						res.pos = mid[POS_W-1:0];
						break;
					end
					if (val > table_mem[mid])
						lo = mid + 1;
					else
						hi = mid;
				end
			end
			REQ_CLEAR: table_fill = 0;
			default: ;
		endcase
		return res;
	endfunction

	function automatic int tx_gap();
		int r;
		if (tx_burst)
			return 0;
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			tx_calm = $urandom_range(10, 50);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// returns at the rising edge where the beat is taken
	task automatic send_beat(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val);
		int gap;
		result_t res;
		gap = tx_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= val;
		s_axis_tuser <= req;
		do @(posedge clk); while (!s_axis_tready);
		res = table_step(req, val);
		awaited_results.push_back(res);
		beats_in++;
		case (req)
			REQ_APPEND: if (res.st == STAT_FULL) appends_dropped++; else appends_ok++;
			REQ_SEARCH: if (res.st == STAT_OK) search_hits++; else search_misses++;
			default: clears_nops++;
		endcase
	endtask

	task automatic load_ascending(input longint first, input int n, input longint step_cap,
			input bit with_dups);
		longint v, cap, lim;
		v = first;
		cap = step_cap;
		lim = (64'sd2147483647 - first) / n;
		if (cap > lim)
			cap = lim;
		for (int i = 0; i < n; i++) begin
			send_beat(REQ_APPEND, v[DATA_W-1:0]);
			if (cap > 0 && !(with_dups && $urandom_range(0, 7) == 0))
				v += longint'($urandom_range(1, int'(cap)));
		end
	endtask

	task automatic probe_keys(input int m);
		int r;
		logic [DATA_W-1:0] key;
		for (int i = 0; i < m; i++) begin
			r = $urandom_range(0, 99);
			if (table_fill > 0 && r < 70)
				key = table_mem[$urandom_range(0, table_fill - 1)];
			else if (table_fill > 0 && r < 85)
				key = table_mem[$urandom_range(0, table_fill - 1)] + ((r & 1) ? 1 : -1);
			else
				key = $urandom;
			send_beat(REQ_SEARCH, key);
		end
	endtask

	task automatic test_empty_table();
		send_beat(REQ_SEARCH, 32'h8000_0000);
		send_beat(REQ_NOP, 32'hFFFF_FFFF);
		send_beat(REQ_CLEAR, 32'h0000_0000);
	endtask

	task automatic test_extremes();
		send_beat(REQ_APPEND, 32'h8000_0000);
		send_beat(REQ_APPEND, 32'hFFFF_FFFF);
		send_beat(REQ_APPEND, 32'h0000_0000);
		send_beat(REQ_APPEND, 32'h0000_0001);
		send_beat(REQ_APPEND, 32'h7FFF_FFFF);
		send_beat(REQ_SEARCH, 32'h8000_0000);
		send_beat(REQ_SEARCH, 32'h7FFF_FFFF);
		send_beat(REQ_SEARCH, 32'h0000_0000);
		send_beat(REQ_SEARCH, 32'h0000_0005);
	endtask

	task automatic test_duplicates();
		send_beat(REQ_CLEAR, 32'h5555_5555);
		send_beat(REQ_APPEND, 32'd3);
		send_beat(REQ_APPEND, 32'd3);
		send_beat(REQ_APPEND, 32'd3);
		send_beat(REQ_APPEND, 32'd7);
		send_beat(REQ_SEARCH, 32'd3);
	endtask

	task automatic test_unsorted();
		send_beat(REQ_CLEAR, 32'hAAAA_AAAA);
		send_beat(REQ_APPEND, 32'd9);
		send_beat(REQ_APPEND, 32'd1);
		send_beat(REQ_APPEND, 32'd5);
		send_beat(REQ_SEARCH, 32'd1);
		send_beat(REQ_SEARCH, 32'd9);
	endtask

	task automatic test_full_table();
		send_beat(REQ_CLEAR, $urandom);
		load_ascending(-64'sd2147483648 + $urandom_range(0, 1000), STBS_DEPTH, 4_000_000, 1'b0);
		send_beat(REQ_SEARCH, table_mem[0]);
		send_beat(REQ_SEARCH, table_mem[STBS_DEPTH-1]);
		send_beat(REQ_SEARCH, table_mem[STBS_DEPTH/2 - 1]);
		send_beat(REQ_SEARCH, 32'h7FFF_FFFF);
		probe_keys(12);
		send_beat(REQ_APPEND, 32'h7FFF_FFFF);
		send_beat(REQ_APPEND, $urandom);
		send_beat(REQ_SEARCH, table_mem[$urandom_range(0, STBS_DEPTH-1)]);
		send_beat(REQ_CLEAR, $urandom);
		send_beat(REQ_SEARCH, $urandom);
	endtask

	// sink holds off while the source keeps offering beats back to back
	task automatic test_backpressure();
		tx_burst = 1'b1;
		stall_req = 1'b1;
		for (int i = 0; i < 24; i++) begin
			if (i % 3 == 0)
				send_beat(REQ_APPEND, $urandom);
			else
				probe_keys(1);
		end
		tx_burst = 1'b0;
	endtask

	task automatic test_random_sessions(input int target);
		int r, n;
		longint first, cap;
		while (beats_in < target) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				send_beat(REQ_CLEAR, $urandom);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
				case ($urandom_range(0, 3))
					0: cap = 3;
					1: cap = 1000;
					2: cap = 1 << 20;
					default: cap = 64'hFFFF_FFFF;
				endcase
				first = longint'($signed($urandom));
				if (n > 40)
					first = -64'sd2147483648 + $urandom_range(0, 1 << 20);
				load_ascending(first, n, cap, $urandom_range(0, 3) == 0);
				probe_keys($urandom_range(1, 30));
			end else begin
				repeat ($urandom_range(1, 12))
					send_beat(REQ_W'($urandom_range(0, 3)), $urandom);
			end
		end
	endtask

	always @(negedge clk) begin
		if (stall_req) begin
			stall_req = 1'b0;
			rx_level = 1'b0;
			rx_left = HOLD_CYCLES;
		end else if (rx_left == 0) begin
			case ($urandom_range(0, 99)) inside
				[0:54]:  begin rx_level = 1'b1; rx_left = $urandom_range(0, 19); end
				[55:89]: begin rx_level = 1'b0; rx_left = $urandom_range(0, 2); end
				[90:96]: begin rx_level = 1'b1; rx_left = $urandom_range(30, 80); end
				default: begin rx_level = 1'b0; rx_left = $urandom_range(15, 40); end
			endcase
		end else begin
			rx_left--;
		end
		m_axis_tready <= rx_level;
	end

	always @(posedge clk) begin : check_beat
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, status %0d tdata %h", $time,
					m_axis_tuser, m_axis_tdata);
			end else begin
				want = awaited_results.pop_front();
				if (m_axis_tuser !== want.st) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.st, m_axis_tuser);
				end
				if (m_axis_tdata !== {{(OUT_TDATA_W-POS_W){1'b0}}, want.pos}) begin
					errors++;
					$display("%0t: tdata expected %h actual %h", $time,
						{{(OUT_TDATA_W-POS_W){1'b0}}, want.pos}, m_axis_tdata);
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_extremes();
		test_duplicates();
		test_unsorted();
		test_full_table();
		test_random_sessions(beats_in + 300);
		test_backpressure();
		test_random_sessions(RANDOM_BEATS + 25);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (awaited_results.size() == 0);
		repeat (40) @(posedge clk);
		$display("%0d beats: %0d appends taken, %0d dropped on a full table, %0d clear/no-op",
			beats_in, appends_ok, appends_dropped, clears_nops);
		$display("searches: %0d hits, %0d misses, up to %0d entries deep",
			search_hits, search_misses, STBS_DEPTH);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#9_000_000;
		$display("timeout with %0d beats still awaited", awaited_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
